@@ rtl/core/combined_lcg_shuffle_uniform_defines.svh @@
// Assertion macros shared by the uniform generator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef COMBINED_LCG_SHUFFLE_UNIFORM_DEFINES_SVH
`define COMBINED_LCG_SHUFFLE_UNIFORM_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CLSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/clsu_pkg.sv @@
// Constants for the combined congruential generator with shuffle table.
// No dependencies; used by the top level combined_lcg_shuffle_uniform.
`default_nettype none

package clsu_pkg;

	// Default number of shuffle table entries.
	localparam int unsigned TABLE_SIZE_DEF = 32;
	// Extra warm-up steps beyond the table size on a reinitializing seed.
	localparam int unsigned WARMUP_EXTRA = 8;

	// Moduli of the two generators and their distance to 2^31.
	localparam logic [30:0] MOD1       = 31'd2147483563;
	localparam logic [30:0] MOD2       = 31'd2147483399;
	localparam logic [30:0] MOD1_LESS1 = 31'd2147483562;
	localparam logic [7:0]  FOLD1      = 8'd85;
	localparam logic [7:0]  FOLD2      = 8'd249;

	// Multipliers of the two generators. The fraction uses 2*FOLD1, since
	// s*2^32 = 2*s*MOD1 + 170*s.
	localparam logic [15:0] MUL1     = 16'd40014;
	localparam logic [15:0] MUL2     = 16'd40692;
	localparam logic [15:0] FRAC_MUL = 16'd170;

	// Reset and saturation values.
	localparam logic [30:0] SECOND_RESET = 31'd123456789;
	localparam logic [30:0] SEED_SAT     = 31'h7FFF_FFFF;
	localparam logic [31:0] FRACTION_CAP = 32'd4294966780;

endpackage

`default_nettype wire

@@ rtl/core/clsu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the shuffle table.
`default_nettype none

module clsu_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/core/combined_lcg_shuffle_uniform.sv @@
// Uniform random generator: two multiplicative congruential generators (moduli
// 2147483563 and 2147483399) combined through a TABLE_SIZE-entry shuffle table.
// A command beat either draws from the stored state or first loads a seed; a seed
// of zero or below reseeds both generators and refills the table with
// TABLE_SIZE+8 warm-up steps. Command beats are stalled from the accepted beat
// until the sequencer returns to idle as the response register loads, so a new
// command is taken only after the last one is through. A reinitializing seed runs
// its warm-up steps before the draw. A stalled response beat holds the sequencer
// in its last step until the response register frees up. The sequencer uses one
// shared multiply-and-fold unit, with a multiply state and a fold state for each
// generator step and one more pass for the fraction, plus a table read and the
// mix. The table index comes from a reciprocal multiplication with one correction
// step, done during the first generator step. The table sits in a RAM with a
// valid bit per entry, so it needs no clearing pass after reset.
// Depends on clsu_pkg, clsu_ram and combined_lcg_shuffle_uniform_defines.svh.
`default_nettype none

`include "combined_lcg_shuffle_uniform_defines.svh"

module combined_lcg_shuffle_uniform #(
	parameter int unsigned TABLE_SIZE = clsu_pkg::TABLE_SIZE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Command channel.
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic               operation,
	input  wire logic signed [31:0] seed_value,
	// Response channel.
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic             [30:0] sample,
	output logic             [31:0] uniform_fraction,
	output logic             [30:0] next_seed
);

	localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
	localparam int unsigned IDX1_W = IDX_W + 1;
	localparam int unsigned RCP_W  = IDX_W + 2;
	localparam int unsigned EST_W  = 31 + RCP_W;
	localparam int unsigned BND_W  = IDX_W + 32;
	localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + clsu_pkg::WARMUP_EXTRA);
	// Width of one table bin; index = sample / BIN_DIV.
	localparam longint unsigned BIN_DIV =
		1 + (longint'(clsu_pkg::MOD1_LESS1)) / TABLE_SIZE;
	localparam logic [31:0] BIN_DIV_W = 32'(BIN_DIV);
	// Reciprocal of the bin width scaled by 2^32; its estimate is low by at most one.
	localparam logic [RCP_W-1:0] IDX_RECIP = RCP_W'((64'd1 << 32) / BIN_DIV);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] WARM_LAST =
		CNT_W'(TABLE_SIZE + clsu_pkg::WARMUP_EXTRA - 1);
	localparam logic [CNT_W-1:0] WARM_FILL = CNT_W'(TABLE_SIZE);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WARM_MUL,
		S_WARM_RED,
		S_G1_MUL,
		S_G1_RED,
		S_G2_MUL,
		S_G2_RED,
		S_READ,
		S_MIX,
		S_FR_MUL,
		S_FR_RED
	} state_t;

	state_t            state_q;
	logic [30:0]       fg_q;
	logic [30:0]       sg_q;
	logic [30:0]       last_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [46:0]       prod_q;
	logic              modsel_q;
	logic [30:0]       smp_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_est_q;
	logic              ent_vld_q;
	logic [TABLE_SIZE-1:0] tbl_vld_q;
	logic              rsp_valid_q;
	logic [30:0]       rsp_sample_q;
	logic [31:0]       rsp_frac_q;
	logic [30:0]       rsp_seed_q;

	logic [15:0]       mul_a;
	logic [30:0]       mul_z;
	logic [46:0]       prod_d;
	logic [15:0]       fold_hi;
	logic [7:0]        fold_c;
	logic [30:0]       mod_c;
	logic [23:0]       fold_mul;
	logic [31:0]       fold_sum;
	logic              red_ge;
	logic [30:0]       red_rem;
	logic [16:0]       red_quo;
	logic [32:0]       frac_sum;
	logic [31:0]       frac_val;
	logic [31:0]       seed_raw;
	logic [31:0]       seed_neg;
	logic              seed_reinit;
	logic [30:0]       seed_mag;
	logic [EST_W-1:0]  est_prod;
	logic [IDX1_W-1:0] idx_next;
	logic [BND_W-1:0]  idx_bound;
	logic [IDX1_W-1:0] idx_fix;
	logic [IDX_W-1:0]  idx_sel;
	logic [30:0]       entry;
	logic signed [32:0] mix_diff;
	logic [30:0]       mix_val;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [30:0]       ram_wdata;
	logic              ram_re;
	logic [30:0]       ram_rdata;
	logic              rsp_take;
	logic              rsp_load;

	// Operand select for the shared multiplier.
	always_comb begin
		case (state_q)
			S_G2_MUL: begin
				mul_a = clsu_pkg::MUL2;
				mul_z = sg_q;
			end
			S_FR_MUL: begin
				mul_a = clsu_pkg::FRAC_MUL;
				mul_z = smp_q;
			end
			default: begin
				mul_a = clsu_pkg::MUL1;
				mul_z = fg_q;
			end
		endcase
	end

	assign prod_d = 47'(mul_a) * 47'(mul_z);

	// Fold stage: P = hi*2^31 + lo is congruent to hi*(2^31 - m) + lo, which
	// stays below 2*m, so one compare and subtract finishes the reduction.
	assign fold_hi  = prod_q[46:31];
	assign fold_c   = modsel_q ? clsu_pkg::FOLD2 : clsu_pkg::FOLD1;
	assign mod_c    = modsel_q ? clsu_pkg::MOD2 : clsu_pkg::MOD1;
	assign fold_mul = 24'(fold_hi) * 24'(fold_c);
	assign fold_sum = {1'b0, prod_q[30:0]} + {8'b0, fold_mul};
	assign red_ge   = fold_sum >= {1'b0, mod_c};
	assign red_rem  = red_ge ? 31'(fold_sum - {1'b0, mod_c}) : fold_sum[30:0];
	assign red_quo  = {1'b0, fold_hi} + 17'(red_ge);

	// Fraction: floor(s*2^32/MOD1) = 2*s + floor(170*s/MOD1), then capped.
	assign frac_sum = {1'b0, smp_q, 1'b0} + 33'(red_quo);
	assign frac_val = (frac_sum > {1'b0, clsu_pkg::FRACTION_CAP}) ?
		clsu_pkg::FRACTION_CAP : frac_sum[31:0];

	// Seed decode: zero or negative reseeds with the magnitude (one for zero, saturated for the most negative value).
	assign seed_raw    = seed_value;
	assign seed_neg    = 32'(-seed_value);
	assign seed_reinit = seed_raw[31] || (seed_raw == '0);
	always_comb begin
		if (seed_raw == '0) begin
			seed_mag = 31'd1;
		end else if (seed_raw == 32'h8000_0000) begin
			seed_mag = clsu_pkg::SEED_SAT;
		end else begin
			seed_mag = seed_neg[30:0];
		end
	end

	// Table index: reciprocal estimate, then one step up if the next bin is reached, clamped to the last entry.
	assign est_prod  = EST_W'(last_q) * EST_W'(IDX_RECIP);
	assign idx_next  = {1'b0, idx_est_q} + IDX1_W'(1);
	assign idx_bound = BND_W'(idx_next) * BND_W'(BIN_DIV_W);
	assign idx_fix   = (BND_W'(last_q) >= idx_bound) ? idx_next : {1'b0, idx_est_q};
	assign idx_sel   = (idx_fix > {1'b0, IDX_MAX}) ? IDX_MAX : idx_fix[IDX_W-1:0];

	// Combine the table entry with the second generator, wrapping below one.
	assign entry    = ent_vld_q ? ram_rdata : '0;
	assign mix_diff = $signed({2'b00, entry}) - $signed({2'b00, sg_q});
	always_comb begin
		if (mix_diff < 33'sd1) begin
			mix_val = 31'(mix_diff + $signed({2'b00, clsu_pkg::MOD1_LESS1}));
		end else begin
			mix_val = mix_diff[30:0];
		end
	end

	// Table port control: warm-up fill, the read and the replacement after each draw.
	assign ram_we    = ((state_q == S_WARM_RED) && (cnt_q < WARM_FILL)) ||
		(state_q == S_MIX);
	assign ram_waddr = (state_q == S_MIX) ? idx_q : cnt_q[IDX_W-1:0];
	assign ram_wdata = (state_q == S_MIX) ? fg_q : red_rem;
	assign ram_re    = state_q == S_READ;

	clsu_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(idx_q),
		.rd_data(ram_rdata)
	);

	assign rsp_take = rsp_valid_q && !rsp_stall;
	assign rsp_load = (state_q == S_FR_RED) && (!rsp_valid_q || !rsp_stall);

	// Sequencer with generator state, index estimate and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fg_q         <= 31'd1;
			sg_q         <= clsu_pkg::SECOND_RESET;
			last_q       <= '0;
			cnt_q        <= '0;
			prod_q       <= '0;
			modsel_q     <= 1'b0;
			smp_q        <= '0;
			idx_q        <= '0;
			idx_est_q    <= '0;
			ent_vld_q    <= 1'b0;
			tbl_vld_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_sample_q <= '0;
			rsp_frac_q   <= '0;
			rsp_seed_q   <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
			if (ram_we) begin
				tbl_vld_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (operation && seed_reinit) begin
							fg_q    <= seed_mag;
							sg_q    <= seed_mag;
							cnt_q   <= WARM_LAST;
							state_q <= S_WARM_MUL;
						end else begin
							if (operation) begin
								fg_q <= seed_raw[30:0];
							end
							state_q <= S_G1_MUL;
						end
					end
				end
				S_WARM_MUL: begin
					prod_q   <= prod_d;
					modsel_q <= 1'b0;
					state_q  <= S_WARM_RED;
				end
				S_WARM_RED: begin
					fg_q <= red_rem;
					if (cnt_q == '0) begin
						last_q  <= red_rem;
						state_q <= S_G1_MUL;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_WARM_MUL;
					end
				end
				S_G1_MUL: begin
					prod_q    <= prod_d;
					modsel_q  <= 1'b0;
					idx_est_q <= est_prod[32 +: IDX_W];
					state_q   <= S_G1_RED;
				end
				S_G1_RED: begin
					fg_q    <= red_rem;
					idx_q   <= idx_sel;
					state_q <= S_G2_MUL;
				end
				S_G2_MUL: begin
					prod_q   <= prod_d;
					modsel_q <= 1'b1;
					state_q  <= S_G2_RED;
				end
				S_G2_RED: begin
					sg_q    <= red_rem;
					state_q <= S_READ;
				end
				S_READ: begin
					ent_vld_q <= tbl_vld_q[idx_q];
					state_q   <= S_MIX;
				end
				S_MIX: begin
					smp_q   <= mix_val;
					last_q  <= mix_val;
					state_q <= S_FR_MUL;
				end
				S_FR_MUL: begin
					prod_q   <= prod_d;
					modsel_q <= 1'b0;
					state_q  <= S_FR_RED;
				end
				S_FR_RED: begin
					if (rsp_load) begin
						rsp_sample_q <= smp_q;
						rsp_frac_q   <= frac_val;
						rsp_seed_q   <= fg_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall        = state_q != S_IDLE;
	assign rsp_valid        = rsp_valid_q;
	assign sample           = rsp_sample_q;
	assign uniform_fraction = rsp_frac_q;
	assign next_seed        = rsp_seed_q;

	// The fold must leave a value below the selected modulus.
	`CLSU_ASSERT_NOW(a_fold_below_mod, (state_q == S_WARM_RED) || (state_q == S_G1_RED) || (state_q == S_G2_RED) || (state_q == S_FR_RED), red_rem < mod_c, "fold result not reduced")
	// The table index stays inside the table when the entry is combined.
	`CLSU_ASSERT_NOW(a_index_in_table, state_q == S_MIX, idx_q <= IDX_MAX, "table index out of range at mix")
	// A response beat carries a nonzero sample and a capped fraction.
	`CLSU_ASSERT_NOW(a_rsp_range, rsp_valid_q, (rsp_sample_q != '0) && (rsp_frac_q <= clsu_pkg::FRACTION_CAP), "response out of range")
	// The last warm-up step hands over to a draw.
	`CLSU_ASSERT_NEXT(a_warm_to_draw, (state_q == S_WARM_RED) && (cnt_q == '0), state_q == S_G1_MUL, "warm-up did not start the draw")

endmodule

`default_nettype wire
